// ===== hdl/bcc_pkg.sv =====
// Package for the bounded coin change block: request and response beats,
// controller states and the command and status bundles between the units.
// No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned AMOUNT_W = 10;
    localparam int unsigned STOCK_W  = 8;
    localparam int unsigned PSTOCK_W = 10;
    localparam int unsigned QOUT_W   = 6;
    localparam int unsigned DOUT_W   = 7;
    localparam int unsigned NOUT_W   = 8;
    localparam int unsigned POUT_W   = 10;
    // amount / 5 fits 8 bits, coin total fits 11 bits
    localparam int unsigned K_W      = 8;
    localparam int unsigned TOT_W    = 11;

    // floor(x / 5) == (x * 205) >> 10 for x < 1024
    localparam int unsigned DIV5_MUL   = 205;
    localparam int unsigned DIV5_SHIFT = 10;

    // per-coin value, in units of five cents
    localparam logic [K_W-1:0] QUARTER_K = 8'd5;
    localparam logic [K_W-1:0] DIME_K    = 8'd2;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [STOCK_W-1:0]  quarter_stock;
        logic [STOCK_W-1:0]  dime_stock;
        logic [STOCK_W-1:0]  nickel_stock;
        logic [PSTOCK_W-1:0] penny_stock;
    } t_coin_req;

    typedef struct packed {
        logic              success;
        logic [QOUT_W-1:0] quarters_out;
        logic [DOUT_W-1:0] dimes_out;
        logic [NOUT_W-1:0] nickels_out;
        logic [POUT_W-1:0] pennies_out;
    } t_coin_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic reject;
        logic last;
    } t_dp_status;

endpackage

// ===== hdl/bcc_datapath.sv =====
// Search datapath: holds the request, walks quarter and dime counts one trial
// per cycle and keeps the best combination. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_datapath #(
    parameter int unsigned AMOUNT_MAX     = 1023,
    parameter int unsigned COIN_STOCK_MAX = 255
) (
    input  logic               i_clk,
    input  bcc_pkg::t_coin_req i_req,
    input  bcc_pkg::t_dp_cmd   i_cmd,
    output bcc_pkg::t_dp_status o_status,
    output bcc_pkg::t_coin_rsp o_rsp
);
    import bcc_pkg::*;

    logic [STOCK_W-1:0]  r_qs, r_ds, r_ns;
    logic [PSTOCK_W-1:0] r_ps;
    logic [2:0]          r_r0;
    logic [K_W-1:0]      r_kq, r_kd;
    logic [QOUT_W-1:0]   r_q;
    logic [DOUT_W-1:0]   r_d;
    logic                r_reject;
    logic                r_found;
    logic [TOT_W-1:0]    r_best;
    logic [QOUT_W-1:0]   r_bq;
    logic [DOUT_W-1:0]   r_bd;
    logic [NOUT_W-1:0]   r_bn;
    logic [POUT_W-1:0]   r_bp;

    logic [AMOUNT_W+K_W-1:0] prod;
    logic [K_W-1:0]          k0;
    logic [AMOUNT_W-1:0]     r0_full;
    logic                    reject;
    logic [K_W-1:0]          n_cnt;
    logic [K_W-1:0]          k_left;
    logic [TOT_W-1:0]        p_cnt;
    logic [TOT_W-1:0]        total;
    logic                    p_ok, better, d_more, q_more;

    // load: amount = 5*k0 + r0, k0 by reciprocal multiply
    always_comb begin
        prod    = i_req.amount * (AMOUNT_W+K_W)'(DIV5_MUL);
        k0      = prod[DIV5_SHIFT +: K_W];
        r0_full = i_req.amount - AMOUNT_W'({k0, 2'b00}) - AMOUNT_W'(k0);
        reject  = (i_req.amount == '0)
               || (32'(i_req.amount) > 32'(AMOUNT_MAX))
               || (32'(i_req.quarter_stock) > 32'(COIN_STOCK_MAX))
               || (32'(i_req.dime_stock) > 32'(COIN_STOCK_MAX))
               || (32'(i_req.nickel_stock) > 32'(COIN_STOCK_MAX));
    end

    // one trial: most nickels within stock, pennies make up the rest
    always_comb begin
        n_cnt  = (r_ns < r_kd) ? r_ns : r_kd;
        k_left = r_kd - n_cnt;
        p_cnt  = TOT_W'(r_r0) + TOT_W'({k_left, 2'b00}) + TOT_W'(k_left);
        p_ok   = p_cnt <= TOT_W'(r_ps);
        total  = TOT_W'(r_q) + TOT_W'(r_d) + TOT_W'(n_cnt) + p_cnt;
        better = p_ok && (!r_found || (total < r_best));
        d_more = (STOCK_W'(r_d) < r_ds) && (r_kd >= DIME_K);
        q_more = (STOCK_W'(r_q) < r_qs) && (r_kq >= QUARTER_K);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qs     <= i_req.quarter_stock;
            r_ds     <= i_req.dime_stock;
            r_ns     <= i_req.nickel_stock;
            r_ps     <= i_req.penny_stock;
            r_r0     <= r0_full[2:0];
            r_kq     <= k0;
            r_kd     <= k0;
            r_q      <= '0;
            r_d      <= '0;
            r_reject <= reject;
            r_found  <= 1'b0;
        end else if (i_cmd.step) begin
            if (better) begin
                r_found <= 1'b1;
                r_best  <= total;
                r_bq    <= r_q;
                r_bd    <= r_d;
                r_bn    <= n_cnt;
                r_bp    <= p_cnt[POUT_W-1:0];
            end
            if (d_more) begin
                r_d  <= r_d + 1'b1;
                r_kd <= r_kd - DIME_K;
            end else if (q_more) begin
                r_q  <= r_q + 1'b1;
                r_d  <= '0;
                r_kq <= r_kq - QUARTER_K;
                r_kd <= r_kq - QUARTER_K;
            end
        end
    end

    assign o_status.reject = r_reject;
    assign o_status.last   = !d_more && !q_more;

    always_comb begin
        o_rsp.success      = r_found;
        o_rsp.quarters_out = r_found ? r_bq : '0;
        o_rsp.dimes_out    = r_found ? r_bd : '0;
        o_rsp.nickels_out  = r_found ? r_bn : '0;
        o_rsp.pennies_out  = r_found ? r_bp : '0;
    end

endmodule

// ===== hdl/bcc_ctrl.sv =====
// Controller state machine: takes a request, steps the search and presents
// the response for one cycle. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bcc_pkg::t_dp_status i_status,
    output logic                o_busy,
    output logic                o_strobe,
    output bcc_pkg::t_dp_cmd    o_cmd
);
    import bcc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_status.reject || i_status.last) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy     = 1'b1;
        o_strobe   = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SEARCH: begin
                o_cmd.step = !i_status.reject;
            end
            ST_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/bounded_coin_change_min_top.sv =====
// After the accept edge the search runs T (quarters, dimes) trials, one per cycle, and
// then strobes the result; T is the sum over q of (dmax(q)+1), at most 2163 at the
// default amount range, and a refused or zero request runs no trial. A new request
// is taken only in idle; busy drops the cycle after the strobe.
// Reset (synchronous, active low) returns the controller to idle; nothing else
// is cleared. The receiver cannot stall: the strobe lasts exactly one cycle.
`timescale 1ns / 1ps

module bounded_coin_change_min_top #(
    parameter int unsigned AMOUNT_MAX     = 1023,
    parameter int unsigned COIN_STOCK_MAX = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request beat: taken when start is high and busy is low
    input  logic               start,
    output logic               busy,
    input  bcc_pkg::t_coin_req i_req,
    // response beat: valid for the single cycle o_strobe is high
    output logic               o_strobe,
    output bcc_pkg::t_coin_rsp o_rsp
);
    import bcc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Controller: idle -> search (one trial per cycle) -> done (strobe).
    // A request that is zero or out of range runs no trial and goes from search to done.
    bcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd)
    );

    // Datapath: the amount is held as 5*k + r; each trial takes the most
    // nickels within stock, fills with pennies and keeps the first combination
    // with the fewest coins, so ties go to fewer quarters, then fewer dimes.
    bcc_datapath #(
        .AMOUNT_MAX     (AMOUNT_MAX),
        .COIN_STOCK_MAX (COIN_STOCK_MAX)
    ) u_dp (
        .i_clk    (i_clk),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_rsp    (o_rsp)
    );

endmodule

// ===== hdl/bcc_checker.sv =====
// Port-level checks for the coin change block, attached by bind.
// Depends on bcc_pkg and bounded_coin_change_min_top.
`timescale 1ns / 1ps

module bcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input bcc_pkg::t_coin_req i_req,
    input logic               o_strobe,
    input bcc_pkg::t_coin_rsp o_rsp
);
    import bcc_pkg::*;

    logic [AMOUNT_W-1:0] r_amount;
    logic [11:0]         paid;

    // hold the amount of the beat in flight
    always_ff @(posedge i_clk) begin
        if (start && !busy) r_amount <= i_req.amount;
    end

    assign paid = 12'(o_rsp.quarters_out) * 12'd25 + 12'(o_rsp.dimes_out) * 12'd10
                + 12'(o_rsp.nickels_out) * 12'd5 + 12'(o_rsp.pennies_out);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe longer than one cycle");

    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_strobe))
        else $error("busy dropped without a response");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_rsp.success |-> paid == 12'd0)
        else $error("failed response carries coins");

    a_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.success |-> paid == 12'(r_amount))
        else $error("coins do not make the amount");

endmodule

bind bounded_coin_change_min_top bcc_checker u_bcc_checker (.*);
